// File: sv/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the flow packet statistics block.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned LenW     = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CntW     = 32;
  localparam int unsigned VsW      = 64;
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 33;
  localparam int unsigned SqrtRemW = 36;

  localparam logic FuncPacket = 1'b0;
  localparam logic FuncReport = 1'b1;
  localparam logic MetricLen  = 1'b0;
  localparam logic MetricGap  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_GAP,
    ST_WF_START,
    ST_WF_DIV,
    ST_WF_MUL,
    ST_WF_VAR,
    ST_REP_SEL,
    ST_REP_DIV,
    ST_REP_SQRT,
    ST_REP_RND,
    ST_REP_OUT
  } fps_state_e;

endpackage

// File: sv/fps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_in_if
// Request channel carrying packet and report items.
// ----------------------------------------------------------------------------
interface fps_in_if #(
  parameter int unsigned TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic                 flow_start;
  logic                 direction_up;
  logic [15:0]          payload_length;
  logic [TIME_BITS-1:0] timestamp_us;

  modport source (output valid, func, flow_start, direction_up, payload_length,
                  timestamp_us, input ready);
  modport sink (input valid, func, flow_start, direction_up, payload_length,
                timestamp_us, output ready);
endinterface

// File: sv/fps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_out_if
// Result channel carrying the statistics records of a report, four per report.
// ----------------------------------------------------------------------------
interface fps_out_if;
  logic        valid;
  logic        ready;
  logic        result_direction;
  logic        metric;
  logic [31:0] min_value;
  logic [31:0] mean_value;
  logic [31:0] max_value;
  logic [31:0] std_value;
  logic        last;

  modport source (output valid, result_direction, metric, min_value, mean_value,
                  max_value, std_value, last, input ready);
  modport sink (input valid, result_direction, metric, min_value, mean_value,
                max_value, std_value, last, output ready);
endinterface

// File: sv/fps_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fps_divider #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/flow_packet_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_packet_statistics
// Per-direction running min, max, mean and variance sum of payload length
// and inter-arrival gap, with a four-record statistics report.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | contents
//  in_if    | in  | valid/ready  | func, flow_start, direction_up, length, time
//  out_if   | out | valid/ready  | direction, metric, min, mean, max, std, last
//
// A packet request runs a Welford pass for the length and then one for the
// gap; the first packet of a direction has no gap and runs only the length
// pass. Each Welford pass has a setup step, a divider start, a run through
// the shared 64-step bit-serial divider, five multiply steps that run four
// partial products through one 32x32 multiplier, and one write-back.
// Each report record passes a select step, the divider, a 32-step square
// root and a rounding step before its result waits for the sink. A record
// with no samples goes from the select step straight to the output.
// The block takes one request at a time; in_if.ready is high only while it
// is idle. A stalled result simply holds the sequencer. Reset is
// asynchronous and sets every direction to its empty state.
module flow_packet_statistics #(
  parameter int unsigned TIME_BITS      = 48,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fps_in_if.sink    in_if,
  fps_out_if.source out_if
);
  import fps_pkg::*;

  // Mean width: a 32-bit value shifted by the fraction bits.
  localparam int unsigned MW = 32 + MEAN_FRAC_BITS;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned SH = 2 * MEAN_FRAC_BITS;

  fps_state_e state_q, state_d;

  // Per-direction statistics, index 1 forward, 0 backward.
  logic [CntW-1:0]      cnt_q   [2];
  logic [LenW-1:0]      lmin_q  [2];
  logic [LenW-1:0]      lmax_q  [2];
  logic [MW-1:0]        lmean_q [2];
  logic [VsW-1:0]       lvs_q   [2];
  logic [TIME_BITS-1:0] ltime_q [2];
  logic [ValW-1:0]      gmin_q  [2];
  logic [ValW-1:0]      gmax_q  [2];
  logic [MW-1:0]        gmean_q [2];
  logic [VsW-1:0]       gvs_q   [2];

  // Latched request.
  logic                 dir_q;
  logic [LenW-1:0]      len_q;
  logic [TIME_BITS-1:0] ts_q;
  logic                 first_q;

  // Working registers of the Welford update.
  logic            wmet_q;
  logic [ValW-1:0] x_q;
  logic [CntW-1:0] n_q;
  logic [MW-1:0]   mean_q;
  logic [VsW-1:0]  vs_q;
  logic            neg_q;
  logic [MW-1:0]   d_q, e_q, nm_q;
  logic [2:0]      mcnt_q;
  logic [63:0]     pp_q;
  logic [1:0]      psh_q;
  logic [PW-1:0]   acc_q;

  // Report and square root registers.
  logic [1:0]          k_q;
  logic [DivNumW-1:0]  q_q;
  logic [SqrtRemW-1:0] srem_q;
  logic [31:0]         root_q;
  logic [5:0]          scnt_q;

  // Result register.
  logic        ovalid_q;
  logic        odir_q, omet_q, olast_q;
  logic [31:0] omin_q, omean_q, omax_q, ostd_q;

  // Shared divider.
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_done;
  logic [DivNumW-1:0] div_quo;

  fps_divider #(.NUM_W(DivNumW), .DEN_W(DivDenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic in_fire, out_fire;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = ovalid_q && out_if.ready;

  // Welford front end: scaled sample and distance to the mean.
  logic [MW-1:0] xs;
  logic          neg;
  logic [MW-1:0] delta;
  assign xs    = {x_q, MEAN_FRAC_BITS'(0)};
  assign neg   = xs < mean_q;
  assign delta = neg ? (mean_q - xs) : (xs - mean_q);

  // Mean step after the divider.
  logic [MW-1:0] step, nm, e_v;
  assign step = div_quo[MW-1:0];
  assign nm   = neg_q ? (mean_q - step) : (mean_q + step);
  assign e_v  = neg_q ? (nm - xs) : (xs - nm);

  // Partial products: d and e split into their low 32 bits and their upper bits.
  logic [31:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (mcnt_q[1:0])
      2'd0: begin ma = d_q[31:0];  mb = e_q[31:0];  end
      2'd1: begin ma = d_q[31:0];  mb = 32'(e_q[MW-1:32]); end
      2'd2: begin ma = 32'(d_q[MW-1:32]); mb = e_q[31:0]; end
      default: begin ma = 32'(d_q[MW-1:32]); mb = 32'(e_q[MW-1:32]); end
    endcase
  end

  logic [PW-1:0] pp_shift;
  always_comb begin
    case (psh_q)
      2'd0:    pp_shift = PW'(pp_q);
      2'd1:    pp_shift = PW'(pp_q) << 32;
      default: pp_shift = PW'(pp_q) << 64;
    endcase
  end

  // Variance increment: product rounded and scaled down, saturating.
  logic [PW:0]    rsum;
  logic [VsW-1:0] inc;
  logic [VsW:0]   vsum;
  logic [VsW-1:0] vs_new;
  assign rsum   = {1'b0, acc_q} + ((PW+1)'(1) << (SH - 1));
  assign inc    = rsum[PW] ? '1 : rsum[PW-1:SH];
  assign vsum   = {1'b0, vs_q} + {1'b0, inc};
  assign vs_new = vsum[VsW] ? '1 : vsum[VsW-1:0];

  // Packet bookkeeping.
  logic [CntW-1:0] cnt_cur, cnt_inc;
  assign cnt_cur = cnt_q[dir_q];
  assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

  logic [TIME_BITS-1:0] tdiff;
  logic [ValW-1:0]      gap;
  assign tdiff = ts_q - ltime_q[dir_q];
  always_comb begin
    if (ts_q < ltime_q[dir_q]) begin
      gap = '0;
    end else if (TIME_BITS > ValW && (tdiff >> ValW) != '0) begin
      gap = '1;
    end else begin
      gap = ValW'(tdiff);
    end
  end

  // Report selection: length forward, length backward, gap forward, gap
  // backward.
  logic            rdir, rmet;
  logic [CntW-1:0] rcnt, rn;
  logic [VsW-1:0]  rvs;
  logic [MW-1:0]   rmean;
  logic [MW:0]     rmean_rnd;
  assign rdir      = ~k_q[0];
  assign rmet      = k_q[1];
  assign rcnt      = cnt_q[rdir];
  assign rn        = (rmet == MetricLen) ? rcnt : ((rcnt > 1) ? rcnt - 1'b1 : '0);
  assign rvs       = (rmet == MetricLen) ? lvs_q[rdir] : gvs_q[rdir];
  assign rmean     = (rmet == MetricLen) ? lmean_q[rdir] : gmean_q[rdir];
  assign rmean_rnd = {1'b0, rmean} + ((MW+1)'(1) << (MEAN_FRAC_BITS - 1));

  // Square root step: two bits of the quotient per cycle.
  logic [SqrtRemW-1:0] srem_sh, trial;
  logic                sge;
  assign srem_sh = {srem_q[SqrtRemW-3:0], q_q[DivNumW-1 -: 2]};
  assign trial   = SqrtRemW'({root_q, 2'b01});
  assign sge     = srem_sh >= trial;

  logic [32:0] root_up;
  assign root_up = {1'b0, root_q} + 33'd1;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_if.func == FuncReport) ? ST_REP_SEL : ST_LEN;
        end
      end
      ST_LEN:      state_d = ST_WF_START;
      ST_GAP:      state_d = ST_WF_START;
      ST_WF_START: begin
        div_start = 1'b1;
        div_num   = DivNumW'({delta, 1'b0}) + DivNumW'(n_q);
        div_den   = {n_q, 1'b0};
        state_d   = ST_WF_DIV;
      end
      ST_WF_DIV: begin
        if (div_done) begin
          state_d = ST_WF_MUL;
        end
      end
      ST_WF_MUL: begin
        if (mcnt_q == 3'd4) begin
          state_d = ST_WF_VAR;
        end
      end
      ST_WF_VAR: begin
        if (wmet_q == MetricLen && !first_q) begin
          state_d = ST_GAP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REP_SEL: begin
        if (rn == '0) begin
          state_d = ST_REP_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = rvs;
          div_den   = DivDenW'(rn);
          state_d   = ST_REP_DIV;
        end
      end
      ST_REP_DIV: begin
        if (div_done) begin
          state_d = ST_REP_SQRT;
        end
      end
      ST_REP_SQRT: begin
        if (scnt_q == 6'd31) begin
          state_d = ST_REP_RND;
        end
      end
      ST_REP_RND:  state_d = ST_REP_OUT;
      ST_REP_OUT: begin
        if (out_fire) begin
          state_d = (k_q == 2'd3) ? ST_IDLE : ST_REP_SEL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        cnt_q[i]   <= '0;
        lmin_q[i]  <= '1;
        lmax_q[i]  <= '0;
        lmean_q[i] <= '0;
        lvs_q[i]   <= '0;
        ltime_q[i] <= '0;
        gmin_q[i]  <= '1;
        gmax_q[i]  <= '0;
        gmean_q[i] <= '0;
        gvs_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          // A flow start clears both directions before the packet.
          if (in_fire && in_if.func == FuncPacket && in_if.flow_start) begin
            for (int i = 0; i < 2; i++) begin
              cnt_q[i]   <= '0;
              lmin_q[i]  <= '1;
              lmax_q[i]  <= '0;
              lmean_q[i] <= '0;
              lvs_q[i]   <= '0;
              ltime_q[i] <= '0;
              gmin_q[i]  <= '1;
              gmax_q[i]  <= '0;
              gmean_q[i] <= '0;
              gvs_q[i]   <= '0;
            end
          end
        end
        ST_LEN: begin
          cnt_q[dir_q] <= cnt_inc;
          if (len_q < lmin_q[dir_q]) lmin_q[dir_q] <= len_q;
          if (len_q > lmax_q[dir_q]) lmax_q[dir_q] <= len_q;
        end
        ST_GAP: begin
          if (gap < gmin_q[dir_q]) gmin_q[dir_q] <= gap;
          if (gap > gmax_q[dir_q]) gmax_q[dir_q] <= gap;
        end
        ST_WF_VAR: begin
          if (wmet_q == MetricLen) begin
            lmean_q[dir_q] <= nm_q;
            lvs_q[dir_q]   <= vs_new;
            if (first_q) ltime_q[dir_q] <= ts_q;
          end else begin
            gmean_q[dir_q] <= nm_q;
            gvs_q[dir_q]   <= vs_new;
            ltime_q[dir_q] <= ts_q;
          end
        end
        ST_REP_SEL: ovalid_q <= (rn == '0);
        ST_REP_RND: ovalid_q <= 1'b1;
        ST_REP_OUT: begin
          if (out_fire) begin
            ovalid_q <= 1'b0;
            k_q      <= k_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dir_q <= in_if.direction_up;
        len_q <= in_if.payload_length;
        ts_q  <= in_if.timestamp_us;
      end
      ST_LEN: begin
        first_q <= (cnt_cur == '0);
        wmet_q  <= MetricLen;
        x_q     <= ValW'(len_q);
        n_q     <= cnt_inc;
        mean_q  <= lmean_q[dir_q];
        vs_q    <= lvs_q[dir_q];
      end
      ST_GAP: begin
        wmet_q <= MetricGap;
        x_q    <= gap;
        n_q    <= cnt_cur - 1'b1;
        mean_q <= gmean_q[dir_q];
        vs_q   <= gvs_q[dir_q];
      end
      ST_WF_START: begin
        neg_q <= neg;
        d_q   <= delta;
      end
      ST_WF_DIV: begin
        nm_q   <= nm;
        e_q    <= e_v;
        mcnt_q <= '0;
        acc_q  <= '0;
      end
      ST_WF_MUL: begin
        // Multiply into the registered product, and add that product to the
        // accumulator in the next cycle.
        pp_q   <= ma * mb;
        psh_q  <= (mcnt_q[1:0] == 2'd0) ? 2'd0 :
                  (mcnt_q[1:0] == 2'd3) ? 2'd2 : 2'd1;
        mcnt_q <= mcnt_q + 1'b1;
        if (mcnt_q != 3'd0) acc_q <= acc_q + pp_shift;
      end
      ST_REP_SEL: begin
        odir_q  <= rdir;
        omet_q  <= rmet;
        olast_q <= (k_q == 2'd3);
        if (rn == '0) begin
          omin_q  <= '0;
          omean_q <= '0;
          omax_q  <= '0;
          ostd_q  <= '0;
        end else if (rmet == MetricLen) begin
          omin_q  <= 32'(lmin_q[rdir]);
          omax_q  <= 32'(lmax_q[rdir]);
          omean_q <= rmean_rnd[MEAN_FRAC_BITS +: 32];
        end else begin
          omin_q  <= gmin_q[rdir];
          omax_q  <= gmax_q[rdir];
          omean_q <= rmean_rnd[MEAN_FRAC_BITS +: 32];
        end
      end
      ST_REP_DIV: begin
        q_q    <= div_quo;
        srem_q <= '0;
        root_q <= '0;
        scnt_q <= '0;
      end
      ST_REP_SQRT: begin
        q_q    <= {q_q[DivNumW-3:0], 2'b00};
        srem_q <= sge ? (srem_sh - trial) : srem_sh;
        root_q <= {root_q[30:0], sge};
        scnt_q <= scnt_q + 1'b1;
      end
      ST_REP_RND: begin
        // The remainder equals q minus root squared; round half up.
        if (srem_q > SqrtRemW'(root_q)) begin
          ostd_q <= root_up[32] ? '1 : root_up[31:0];
        end else begin
          ostd_q <= root_q;
        end
      end
      default: ;
    endcase
  end

  assign in_if.ready             = (state_q == ST_IDLE);
  assign out_if.valid            = ovalid_q;
  assign out_if.result_direction = odir_q;
  assign out_if.metric           = omet_q;
  assign out_if.min_value        = omin_q;
  assign out_if.mean_value       = omean_q;
  assign out_if.max_value        = omax_q;
  assign out_if.std_value        = ostd_q;
  assign out_if.last             = olast_q;

endmodule

// File: sim/tb_flow_packet_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_packet_statistics
// Self-checking bench for the per-direction flow statistics block.
// ----------------------------------------------------------------------------
// First, a table of directed requests is driven. It covers the empty state
// after reset, the extreme lengths and timestamps, a gap that goes backward
// in time, a gap that saturates, a flow start that clears both directions,
// and a flow start on a report, which is ignored.
// Then random flows follow. Timestamps mostly increase, with some noise.
// Every accepted request goes through a local copy of the statistics. Each
// report adds four expected records to a queue. Each record that comes out
// is compared, field by field, with the oldest entry in that queue.
// Both sides idle at random. Once, the result side holds off for a long
// stretch so that the block stalls its request channel.
module tb_flow_packet_statistics;
  import fps_pkg::*;

  localparam int unsigned TimeW = 48;

  typedef struct packed {
    logic        dir;
    logic        metric;
    logic [31:0] min_v;
    logic [31:0] mean_v;
    logic [31:0] max_v;
    logic [31:0] std_v;
    logic        last;
  } stat_rec_t;

  typedef struct {
    logic             func;
    logic             flow_start;
    logic             dir_up;
    logic [15:0]      len;
    logic [TimeW-1:0] ts;
    bit               typed_zero;  // expected report is all zeros, typed in
  } req_row_t;

  logic clk_i;
  logic rst_ni;

  fps_in_if #(.TIME_BITS(TimeW)) req_ch ();
  fps_out_if                     rec_ch ();

  flow_packet_statistics #(
    .TIME_BITS     (TimeW),
    .MEAN_FRAC_BITS(16)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (req_ch),
    .out_if(rec_ch)
  );

  // Local copy of the per-direction statistics (index 1 forward).
  logic [31:0]      pkt_cnt[2];
  logic [15:0]      len_min[2];
  logic [15:0]      len_max[2];
  logic [63:0]      len_mean[2];
  logic [63:0]      len_vs[2];
  logic [TimeW-1:0] prev_ts[2];
  logic [31:0]      gap_min[2];
  logic [31:0]      gap_max[2];
  logic [63:0]      gap_mean[2];
  logic [63:0]      gap_vs[2];

  stat_rec_t expected_recs[$];
  int        n_errors;
  int        n_checked;
  int        n_packets;
  int        n_reports;
  bit        hold_req;
  bit        sender_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Safety net: the slowest correct run is far below this.
  initial begin
    #(12 * 1500000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void clear_flow();
    for (int k = 0; k < 2; k++) begin
      pkt_cnt[k]  = '0;
      len_min[k]  = '1;
      len_max[k]  = '0;
      len_mean[k] = '0;
      len_vs[k]   = '0;
      prev_ts[k]  = '0;
      gap_min[k]  = '1;
      gap_max[k]  = '0;
      gap_mean[k] = '0;
      gap_vs[k]   = '0;
    end
  endfunction

  // One Welford step in Q.16. The mean moves by d/n, rounded half away
  // from zero. The variance sum grows by d*e / 2^32, rounded half up, and
  // saturates at 64 bits.
  function automatic void welford_step(input logic [63:0] x, input logic [63:0] n,
                                       inout logic [63:0] mean, inout logic [63:0] vs);
    logic [63:0]  xs, d, step, nm, e, inc;
    logic [127:0] prod;
    logic [64:0]  sum;
    bit           neg;
    xs   = x << 16;
    neg  = xs < mean;
    d    = neg ? mean - xs : xs - mean;
    step = (2 * d + n) / (2 * n);
    nm   = neg ? mean - step : mean + step;
    e    = neg ? nm - xs : xs - nm;
    prod = {64'd0, d} * {64'd0, e};
    prod = prod + (128'd1 << 31);
    inc  = (prod[127:96] != 0) ? '1 : prod[95:32];
    sum  = {1'b0, vs} + {1'b0, inc};
    vs   = sum[64] ? '1 : sum[63:0];
    mean = nm;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic stat_rec_t summarize(input logic dir, input logic metric,
                                          input logic [63:0] n, input logic [63:0] mn,
                                          input logic [63:0] mean, input logic [63:0] mx,
                                          input logic [63:0] vs, input logic last);
    stat_rec_t   rec;
    logic [63:0] q, r, rnd;
    rec = '0;
    rec.dir    = dir;
    rec.metric = metric;
    rec.last   = last;
    if (n != 0) begin
      q = vs / n;
      r = int_sqrt(q);
      if (q - r * r > r) r = r + 1;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      rnd = (mean + (64'd1 << 15)) >> 16;
      rec.min_v  = mn[31:0];
      rec.mean_v = rnd[31:0];
      rec.max_v  = mx[31:0];
      rec.std_v  = r[31:0];
    end
    return rec;
  endfunction

  // Applies one accepted request to the local statistics and queues the
  // records that a report is expected to produce.
  function automatic void apply_request(input req_row_t rq);
    logic [63:0] gap;
    logic [63:0] ng;
    int          d, dir;
    bit          first;
    logic        metric;
    if (rq.func == FuncReport) begin
      n_reports++;
      for (int k = 0; k < 4; k++) begin
        dir    = (k & 1) ? 0 : 1;
        metric = (k >> 1) ? MetricGap : MetricLen;
        ng     = (pkt_cnt[dir] > 1) ? pkt_cnt[dir] - 1 : 0;
        if (rq.typed_zero)
          expected_recs.push_back('{dir: dir[0], metric: metric, min_v: 32'd0,
                                    mean_v: 32'd0, max_v: 32'd0, std_v: 32'd0,
                                    last: (k == 3)});
        else if (metric == MetricLen)
          expected_recs.push_back(summarize(dir[0], metric, pkt_cnt[dir], len_min[dir],
                                            len_mean[dir], len_max[dir], len_vs[dir],
                                            k == 3));
        else
          expected_recs.push_back(summarize(dir[0], metric, ng, gap_min[dir],
                                            gap_mean[dir], gap_max[dir], gap_vs[dir],
                                            k == 3));
      end
      return;
    end
    n_packets++;
    if (rq.flow_start) clear_flow();
    d     = rq.dir_up;
    first = (pkt_cnt[d] == 0);
    if (pkt_cnt[d] != '1) pkt_cnt[d] = pkt_cnt[d] + 1;
    if (rq.len < len_min[d]) len_min[d] = rq.len;
    if (rq.len > len_max[d]) len_max[d] = rq.len;
    welford_step(rq.len, pkt_cnt[d], len_mean[d], len_vs[d]);
    if (!first) begin
      // A timestamp that goes backward gives a zero gap. A huge gap clamps
      // to 32 bits.
      gap = (rq.ts < prev_ts[d]) ? 64'd0 : rq.ts - prev_ts[d];
      if (gap > 64'hFFFF_FFFF) gap = 64'hFFFF_FFFF;
      if (gap < gap_min[d]) gap_min[d] = gap[31:0];
      if (gap > gap_max[d]) gap_max[d] = gap[31:0];
      welford_step(gap, pkt_cnt[d] - 1, gap_mean[d], gap_vs[d]);
    end
    prev_ts[d] = rq.ts;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // Drives one request and returns once it is accepted. The valid signal
  // stays high across back-to-back requests.
  task automatic send_request(input req_row_t rq, input int idle);
    if (idle > 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.func           <= rq.func;
    req_ch.flow_start     <= rq.flow_start;
    req_ch.direction_up   <= rq.dir_up;
    req_ch.payload_length <= rq.len;
    req_ch.timestamp_us   <= rq.ts;
    do @(posedge clk_i); while (!req_ch.ready);
    apply_request(rq);
  endtask

  function automatic req_row_t random_request(inout logic [TimeW-1:0] tnext[2]);
    req_row_t rq;
    int       r;
    rq = '{default: '0};
    r  = $urandom_range(0, 99);
    if (r < 10) begin
      rq.func       = FuncReport;
      rq.flow_start = 1'($urandom_range(0, 1));
      rq.dir_up     = 1'($urandom_range(0, 1));
      rq.len        = 16'($urandom);
      rq.ts         = TimeW'({$urandom, $urandom});
      return rq;
    end
    rq.func       = FuncPacket;
    rq.flow_start = (r < 14);
    rq.dir_up     = 1'($urandom_range(0, 1));
    rq.len        = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    r = $urandom_range(0, 99);
    if (r < 75)
      rq.ts = tnext[rq.dir_up] + $urandom_range(0, 5000);
    else if (r < 82)
      rq.ts = tnext[rq.dir_up] + (48'd1 << $urandom_range(30, 36));
    else if (r < 91)
      rq.ts = TimeW'({$urandom, $urandom});
    else
      rq.ts = tnext[rq.dir_up] - $urandom_range(0, 3000);
    tnext[rq.dir_up] = rq.ts;
    return rq;
  endfunction

  // Stimulus: the directed table, then random flows.
  initial begin
    req_row_t         dir_table[$];
    req_row_t         rq;
    logic [TimeW-1:0] tnext[2];
    int               n_rand;
    req_ch.valid          <= 1'b0;
    req_ch.func           <= FuncPacket;
    req_ch.flow_start     <= 1'b0;
    req_ch.direction_up   <= 1'b0;
    req_ch.payload_length <= '0;
    req_ch.timestamp_us   <= '0;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    sender_done = 1'b0;
    n_errors    = 0;
    n_checked   = 0;
    n_packets   = 0;
    n_reports   = 0;
    clear_flow();

    dir_table = '{
      '{FuncReport, 1'b0, 1'b0, 16'h0000, 48'd0,              1'b1},
      '{FuncPacket, 1'b1, 1'b1, 16'h0000, 48'd1000,           1'b0},
      '{FuncPacket, 1'b0, 1'b1, 16'hFFFF, 48'd500,            1'b0},
      '{FuncPacket, 1'b0, 1'b1, 16'd100,  48'h100_0000_01F4,  1'b0},
      '{FuncReport, 1'b0, 1'b0, 16'h0000, 48'd0,              1'b0},
      '{FuncPacket, 1'b0, 1'b0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{FuncReport, 1'b0, 1'b1, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{FuncPacket, 1'b0, 1'b0, 16'h0000, 48'd0,              1'b0},
      '{FuncPacket, 1'b0, 1'b0, 16'd7,    48'h5555_5555_5555, 1'b0},
      '{FuncReport, 1'b1, 1'b0, 16'h0000, 48'd0,              1'b0},
      '{FuncPacket, 1'b1, 1'b0, 16'd1,    48'd10,             1'b0},
      '{FuncReport, 1'b0, 1'b0, 16'h0000, 48'd0,              1'b0},
      '{FuncPacket, 1'b0, 1'b1, 16'hAAAA, 48'hAAAA_AAAA_AAAA, 1'b0},
      '{FuncPacket, 1'b0, 1'b1, 16'h5555, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{FuncPacket, 1'b0, 1'b1, 16'd300,  48'hFFFF_FFFF_FFFF, 1'b0},
      '{FuncPacket, 1'b0, 1'b0, 16'd40,   48'd12,             1'b0},
      '{FuncReport, 1'b0, 1'b0, 16'h0000, 48'd0,              1'b0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_request(dir_table[i], pick_gap());

    tnext[0] = 48'd5000;
    tnext[1] = 48'd9000;
    n_rand   = 0;
    while (n_rand < 295) begin
      rq = random_request(tnext);
      // Partway through, the result side goes quiet for a long stretch
      // while a report is pending, so requests pile up at the input.
      if (n_rand == 120) begin
        hold_req = 1'b1;
        rq.func  = FuncReport;
      end
      send_request(rq, pick_gap());
      n_rand++;
    end
    rq = '{default: '0};
    rq.func = FuncReport;
    send_request(rq, 0);
    req_ch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  task automatic check_record();
    stat_rec_t got, want;
    got = '{dir: rec_ch.result_direction, metric: rec_ch.metric,
            min_v: rec_ch.min_value, mean_v: rec_ch.mean_value,
            max_v: rec_ch.max_value, std_v: rec_ch.std_value, last: rec_ch.last};
    n_checked++;
    if (expected_recs.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("ERROR: unexpected record %p", got);
      return;
    end
    want = expected_recs.pop_front();
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 10) $display("ERROR: record %0d expected %p got %p",
                                   n_checked, want, got);
    end
  endtask

  // Result side: random back-pressure, checked at every accepting edge.
  initial begin
    int  stall_left;
    bit  steady;
    rec_ch.ready <= 1'b0;
    stall_left = 0;
    steady     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rec_ch.valid && rec_ch.ready) check_record();
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        rec_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) steady = !steady;
        if (steady || $urandom_range(0, 99) < 70) begin
          rec_ch.ready <= 1'b1;
        end else begin
          rec_ch.ready <= 1'b0;
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(20, 120);
        end
      end
    end
  end

  // End of run: drain, let the block settle, then report.
  initial begin
    int waited;
    wait (sender_done);
    waited = 0;
    while (expected_recs.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (1000) @(posedge clk_i);
    if (expected_recs.size() != 0) begin
      n_errors++;
      $display("ERROR: %0d expected records never arrived", expected_recs.size());
    end
    $display("Run covered %0d packet requests and %0d reports, %0d records checked.",
             n_packets, n_reports, n_checked);
    $display("Mismatches counted: %0d.", n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
